/* design/pp2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// pp2rgb_pkg
// Shared types, format codes and color math constants for the packed pixel
// to RGB888 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pp2rgb_pkg;

	// Format register codes
	localparam logic [2:0] FMT_YUYV      = 3'd0;
	localparam logic [2:0] FMT_YUV565    = 3'd1;
	localparam logic [2:0] FMT_RGB565_BE = 3'd2;
	localparam logic [2:0] FMT_RGB565_LE = 3'd3;
	localparam logic [2:0] FMT_RAW       = 3'd4;

	// BT.601 studio range coefficients (8 fractional bits)
	localparam logic signed [19:0] YUYV_Y_OFS  = 20'sd16;
	localparam logic signed [19:0] YUYV_C_OFS  = 20'sd128;
	localparam logic signed [19:0] YUYV_K_Y    = 20'sd298;
	localparam logic signed [19:0] YUYV_K_RV   = 20'sd409;
	localparam logic signed [19:0] YUYV_K_GU   = 20'sd100;
	localparam logic signed [19:0] YUYV_K_GV   = 20'sd208;
	localparam logic signed [19:0] YUYV_K_BU   = 20'sd516;
	localparam logic signed [19:0] YUYV_ROUND  = 20'sd128;

	// Full range YCbCr coefficients (16 fractional bits)
	localparam logic [25:0] YUV_K_RCR = 26'd91881;
	localparam logic [25:0] YUV_K_GCB = 26'd22544;
	localparam logic [25:0] YUV_K_GCR = 26'd46793;
	localparam logic [25:0] YUV_K_BCB = 26'd116129;
	localparam logic signed [19:0] YUV_R_OFS = 20'sd179;
	localparam logic signed [19:0] YUV_G_OFS = 20'sd135;
	localparam logic signed [19:0] YUV_B_OFS = 20'sd226;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// Saturate a signed intermediate to 0..255
	function automatic logic [7:0] clip8(input logic signed [19:0] v);
		logic [7:0] res;
		if (v < 20'sd0) begin
			res = 8'd0;
		end else if (v > 20'sd255) begin
			res = 8'd255;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

/* design/pp2rgb_pix_if.sv */
// ----------------------------------------------------------------------------
// pp2rgb_pix_if
// Valid/ready channel carrying one packed 4-byte pixel word and frame end.
// ----------------------------------------------------------------------------
`default_nettype none

interface pp2rgb_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_a;
	logic [7:0] byte_b;
	logic [7:0] byte_c;
	logic [7:0] byte_d;
	logic       frame_end;

	modport source (
		output valid, byte_a, byte_b, byte_c, byte_d, frame_end,
		input  ready
	);
	modport sink (
		input  valid, byte_a, byte_b, byte_c, byte_d, frame_end,
		output ready
	);
endinterface

`default_nettype wire

/* design/pp2rgb_rgb_if.sv */
// ----------------------------------------------------------------------------
// pp2rgb_rgb_if
// Valid/ready channel carrying two RGB888 pixels and the frame end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface pp2rgb_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_first;
	logic [7:0] green_first;
	logic [7:0] blue_first;
	logic [7:0] red_second;
	logic [7:0] green_second;
	logic [7:0] blue_second;
	logic       frame_end_out;

	modport source (
		output valid, red_first, green_first, blue_first,
		       red_second, green_second, blue_second, frame_end_out,
		input  ready
	);
	modport sink (
		input  valid, red_first, green_first, blue_first,
		       red_second, green_second, blue_second, frame_end_out,
		output ready
	);
endinterface

`default_nettype wire

/* design/pp2rgb_pix_dec.sv */
// ----------------------------------------------------------------------------
// pp2rgb_pix_dec
// Combinational decode of one pixel (two bytes, plus shared chroma for YUYV)
// into a clipped RGB888 triple.
// ----------------------------------------------------------------------------
`default_nettype none

module pp2rgb_pix_dec (
	input  wire logic [2:0]        fmt,
	input  wire logic [7:0]        p,
	input  wire logic [7:0]        q,
	input  wire logic [7:0]        u,
	input  wire logic [7:0]        v,
	output pp2rgb_pkg::rgb_t       rgb
);

	// YUYV path: p is luma, u/v shared chroma
	logic signed [19:0] c_yy, d_yy, e_yy;
	logic signed [19:0] r_yy, g_yy, b_yy;
	// YUV565 path
	logic [7:0]         y_565, cb_565, cr_565;
	logic [25:0]        r_prod, g_prod, b_prod;
	logic signed [19:0] r_565, g_565, b_565;

	always_comb begin
		c_yy = $signed({12'd0, p}) - pp2rgb_pkg::YUYV_Y_OFS;
		d_yy = $signed({12'd0, u}) - pp2rgb_pkg::YUYV_C_OFS;
		e_yy = $signed({12'd0, v}) - pp2rgb_pkg::YUYV_C_OFS;
		r_yy = (pp2rgb_pkg::YUYV_K_Y * c_yy + pp2rgb_pkg::YUYV_K_RV * e_yy
			+ pp2rgb_pkg::YUYV_ROUND) >>> 8;
		g_yy = (pp2rgb_pkg::YUYV_K_Y * c_yy - pp2rgb_pkg::YUYV_K_GU * d_yy
			- pp2rgb_pkg::YUYV_K_GV * e_yy + pp2rgb_pkg::YUYV_ROUND) >>> 8;
		b_yy = (pp2rgb_pkg::YUYV_K_Y * c_yy + pp2rgb_pkg::YUYV_K_BU * d_yy
			+ pp2rgb_pkg::YUYV_ROUND) >>> 8;
	end

	always_comb begin
		y_565  = {q[7:3], 3'd0};
		cb_565 = {q[2:0], p[7:5], 2'd0};
		cr_565 = {p[4:0], 3'd0};
		// all products are non-negative, so the shift is a plain select
		r_prod = 26'(cr_565) * pp2rgb_pkg::YUV_K_RCR;
		g_prod = 26'(cb_565) * pp2rgb_pkg::YUV_K_GCB
			+ 26'(cr_565) * pp2rgb_pkg::YUV_K_GCR;
		b_prod = 26'(cb_565) * pp2rgb_pkg::YUV_K_BCB;
		r_565  = $signed({12'd0, y_565}) + $signed({10'd0, r_prod[25:16]})
			- pp2rgb_pkg::YUV_R_OFS;
		g_565  = $signed({12'd0, y_565}) - $signed({10'd0, g_prod[25:16]})
			+ pp2rgb_pkg::YUV_G_OFS;
		b_565  = $signed({12'd0, y_565}) + $signed({10'd0, b_prod[25:16]})
			- pp2rgb_pkg::YUV_B_OFS;
	end

	always_comb begin
		unique case (fmt)
			pp2rgb_pkg::FMT_YUYV: begin
				rgb.red   = pp2rgb_pkg::clip8(r_yy);
				rgb.green = pp2rgb_pkg::clip8(g_yy);
				rgb.blue  = pp2rgb_pkg::clip8(b_yy);
			end
			pp2rgb_pkg::FMT_YUV565: begin
				rgb.red   = pp2rgb_pkg::clip8(r_565);
				rgb.green = pp2rgb_pkg::clip8(g_565);
				rgb.blue  = pp2rgb_pkg::clip8(b_565);
			end
			pp2rgb_pkg::FMT_RGB565_BE: begin
				rgb.red   = {p[7:3], 3'd0};
				rgb.green = {p[2:0], q[7:5], 2'd0};
				rgb.blue  = {q[4:0], 3'd0};
			end
			pp2rgb_pkg::FMT_RGB565_LE: begin
				rgb.red   = {q[7:3], 3'd0};
				rgb.green = {q[2:0], p[7:5], 2'd0};
				rgb.blue  = {p[4:0], 3'd0};
			end
			pp2rgb_pkg::FMT_RAW: begin
				rgb.red   = p;
				rgb.green = q;
				rgb.blue  = 8'd0;
			end
			default: begin
				rgb = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/packed_pixel_to_rgb888.sv */
// ----------------------------------------------------------------------------
// packed_pixel_to_rgb888
// Converts one packed 4-byte pixel word per item into two RGB888 pixels.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output side is ready and
// returns one result item per input item. The input word lands in an input
// register; the color decode (constant multiplies, adds and clips for both
// pixels) sits between that register and the result register, so sustained
// throughput is one item every cycle while the output side does not stall,
// set by that single decode stage. When the output side stalls, the result
// register holds its item and the input register keeps accepting one more,
// so pix_in.ready only drops once both registers are full. The format register
// (cfg_wdata, written when cfg_we is high) selects YUYV (BT.601 studio
// range, shared chroma), packed YUV565 (full range), RGB565 big or little
// endian, or raw; codes above raw give black pixels. Change the format only
// while no item is in flight. frame_end is carried through unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_pixel_to_rgb888 (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_wdata,
	pp2rgb_pix_if.sink      pix_in,
	pp2rgb_rgb_if.source    rgb_out
);

	// Format register
	logic [2:0] fmt_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_a_s1, byte_b_s1, byte_c_s1, byte_d_s1;
	logic       frame_end_s1;

	// Result stage
	logic                valid_s2;
	pp2rgb_pkg::rgb_t    pix0_s2, pix1_s2;
	logic                frame_end_s2;

	pp2rgb_pkg::rgb_t    pix0_dec, pix1_dec;
	logic                load_s1, load_s2;

	// Advance the result stage when it is empty or its item is being taken;
	// advance the input stage when it is empty or its item moves on.
	assign load_s2     = !valid_s2 || rgb_out.ready;
	assign load_s1     = !valid_s1 || load_s2;
	assign pix_in.ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= pp2rgb_pkg::FMT_YUYV;
		end else if (cfg_we) begin
			fmt_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= pix_in.valid;
		end
	end

	// Capture the payload only on acceptance
	always_ff @(posedge clk) begin
		if (load_s1 && pix_in.valid) begin
			byte_a_s1    <= pix_in.byte_a;
			byte_b_s1    <= pix_in.byte_b;
			byte_c_s1    <= pix_in.byte_c;
			byte_d_s1    <= pix_in.byte_d;
			frame_end_s1 <= pix_in.frame_end;
		end
	end

	// First pixel: bytes a/b; second pixel: bytes c/d. YUYV shares U (b) and V (d).
	pp2rgb_pix_dec u_dec0 (
		.fmt (fmt_q),
		.p   (byte_a_s1),
		.q   (byte_b_s1),
		.u   (byte_b_s1),
		.v   (byte_d_s1),
		.rgb (pix0_dec)
	);

	pp2rgb_pix_dec u_dec1 (
		.fmt (fmt_q),
		.p   (byte_c_s1),
		.q   (byte_d_s1),
		.u   (byte_b_s1),
		.v   (byte_d_s1),
		.rgb (pix1_dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Hold the result while the output side stalls
	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			pix0_s2      <= pix0_dec;
			pix1_s2      <= pix1_dec;
			frame_end_s2 <= frame_end_s1;
		end
	end

	assign rgb_out.valid         = valid_s2;
	assign rgb_out.red_first     = pix0_s2.red;
	assign rgb_out.green_first   = pix0_s2.green;
	assign rgb_out.blue_first    = pix0_s2.blue;
	assign rgb_out.red_second    = pix1_s2.red;
	assign rgb_out.green_second  = pix1_s2.green;
	assign rgb_out.blue_second   = pix1_s2.blue;
	assign rgb_out.frame_end_out = frame_end_s2;

endmodule

`default_nettype wire

/* design/pp2rgb_chk.sv */
// ----------------------------------------------------------------------------
// pp2rgb_chk
// Port-level checks for the packed pixel converter: occupancy and output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module pp2rgb_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_red_first,
	input wire logic [7:0] out_blue_second,
	input wire logic       out_frame_end
);

	logic       in_acc, out_acc;
	logic [2:0] occ_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Track items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 3'd0;
		end else begin
			occ_q <= occ_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red_first)
			&& $stable(out_blue_second) && $stable(out_frame_end))
		else $error("result item changed while stalled");

	a_occ_max: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 3'd2)
		else $error("more than two items in flight");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q < 3'd2 |-> in_ready)
		else $error("input stalled with free storage");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == 3'd0 |-> !out_valid)
		else $error("result item with nothing in flight");

endmodule

bind packed_pixel_to_rgb888 pp2rgb_chk u_pp2rgb_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (pix_in.valid),
	.in_ready        (pix_in.ready),
	.out_valid       (rgb_out.valid),
	.out_ready       (rgb_out.ready),
	.out_red_first   (rgb_out.red_first),
	.out_blue_second (rgb_out.blue_second),
	.out_frame_end   (rgb_out.frame_end_out)
);

`default_nettype wire
